[rtl/assert_macros.svh]
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, with reset masking the check
`define ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/fsq_pkg.sv]
// Shared types and constants of the packet fragmenter
package fsq_pkg;

  localparam int unsigned PREFIX_BYTES = 4;
  localparam logic [15:0] MIN_PAYLOAD = 16'd5;
  localparam logic [15:0] RESET_PAYLOAD = 16'd508;
  localparam int unsigned BEAT_W = 3;
  localparam logic [BEAT_W-1:0] LAST_BEAT = BEAT_W'(PREFIX_BYTES);

  // One accepted input transaction
  typedef struct packed {
    logic [7:0]  data_byte;
    logic [31:0] message_length;
    logic        first_byte;
  } in_item_t;

  // One decided run of results for the emitter
  typedef struct packed {
    logic [7:0]  data_byte;
    logic [31:0] length;
    logic [31:0] sequence_num;
    logic        fragmented;
    logic        packet_end;
    logic        prefix;
  } work_t;

endpackage

[rtl/fsq_input_reg.sv]
// Input register that holds one accepted transaction until the core takes it
module fsq_input_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       data_byte,
  input  logic [31:0]      message_length,
  input  logic             first_byte,
  input  logic             pop,
  output logic             full,
  output fsq_pkg::in_item_t item
);
  import fsq_pkg::*;

  // Take a new transaction when empty or when the held one leaves now
  assign in_ready = !full || pop;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_valid && in_ready) begin
      full <= 1'b1;
    end else if (pop) begin
      full <= 1'b0;
    end
  end

  // Capture the payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.data_byte      <= data_byte;
      item.message_length <= message_length;
      item.first_byte     <= first_byte;
    end
  end

endmodule

[rtl/fsq_seq_core.sv]
// Fragmentation state, sequence counter and per-byte decision logic
module fsq_seq_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [15:0]       cfg_wr_data,
  input  logic              full,
  input  fsq_pkg::in_item_t item,
  output logic              pop,
  input  logic              work_free,
  output logic              work_load,
  output fsq_pkg::work_t    work_entry
);
  import fsq_pkg::*;

  logic [15:0] payload_len;
  logic [31:0] sequence_counter;
  logic [31:0] message_bytes_left;
  logic [15:0] packet_bytes_left;
  logic        in_fragmented_message;

  logic [31:0] sequence_counter_next;
  logic [31:0] message_bytes_left_next;
  logic [15:0] packet_bytes_left_next;
  logic        in_fragmented_message_next;

  logic [15:0] p;
  logic [31:0] len0;
  logic        too_long;
  logic        ignore;
  logic [15:0] pkt_new;

  // Clamp the payload register to the smallest usable packet
  assign p = (payload_len < MIN_PAYLOAD) ? MIN_PAYLOAD : payload_len;
  assign len0 = (item.message_length == 32'd0) ? 32'd1 : item.message_length;
  assign too_long = len0 > {16'd0, p};
  assign ignore = !item.first_byte && (message_bytes_left == 32'd0);
  assign pkt_new = (message_bytes_left < {16'd0, p}) ? message_bytes_left[15:0] : p;

  // Drop ignored bytes at once; move others when the emitter frees up
  assign pop = full && (ignore || work_free);
  assign work_load = full && !ignore && work_free;

  // Decide the next state for the held byte
  always_comb begin
    sequence_counter_next      = sequence_counter;
    in_fragmented_message_next = in_fragmented_message;
    message_bytes_left_next    = message_bytes_left - 32'd1;
    packet_bytes_left_next     = packet_bytes_left - 16'd1;
    if (item.first_byte) begin
      sequence_counter_next   = sequence_counter + 32'd1;
      message_bytes_left_next = len0 - 32'd1;
      if (too_long) begin
        in_fragmented_message_next = 1'b1;
        packet_bytes_left_next     = p - 16'(PREFIX_BYTES) - 16'd1;
      end else begin
        in_fragmented_message_next = 1'b0;
        packet_bytes_left_next     = len0[15:0] - 16'd1;
      end
    end else if (packet_bytes_left == 16'd0) begin
      sequence_counter_next  = sequence_counter + 32'd1;
      packet_bytes_left_next = pkt_new - 16'd1;
    end
  end

  // Build the run handed to the emitter
  always_comb begin
    work_entry.data_byte    = item.data_byte;
    work_entry.length       = len0;
    work_entry.sequence_num = sequence_counter_next;
    work_entry.fragmented   = in_fragmented_message_next;
    work_entry.packet_end   = (packet_bytes_left_next == 16'd0);
    work_entry.prefix       = item.first_byte && too_long;
  end

  // Hold the configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      payload_len <= RESET_PAYLOAD;
    end else if (cfg_wr_en) begin
      payload_len <= cfg_wr_data;
    end
  end

  // Advance the state when a byte is handed to the emitter
  always_ff @(posedge clk) begin
    if (rst) begin
      sequence_counter      <= '1;
      message_bytes_left    <= '0;
      packet_bytes_left     <= '0;
      in_fragmented_message <= 1'b0;
    end else if (work_load) begin
      sequence_counter      <= sequence_counter_next;
      message_bytes_left    <= message_bytes_left_next;
      packet_bytes_left     <= packet_bytes_left_next;
      in_fragmented_message <= in_fragmented_message_next;
    end
  end

endmodule

[rtl/fsq_emitter.sv]
// Result register that plays out the length prefix and the data byte
module fsq_emitter (
  input  logic           clk,
  input  logic           rst,
  input  logic           work_load,
  input  fsq_pkg::work_t work_entry,
  output logic           work_free,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic [31:0]    packet_sequence,
  output logic           fragmented,
  output logic           packet_end,
  output logic           run_last
);
  import fsq_pkg::*;

  work_t             work;
  logic              work_valid;
  logic [BEAT_W-1:0] beat;
  logic              last;
  logic              done;

  assign last = !work.prefix || (beat == LAST_BEAT);
  assign done = work_valid && out_ready && last;
  assign work_free = !work_valid || done;

  // Hold the run and step through its beats
  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
      beat       <= '0;
    end else if (work_load) begin
      work_valid <= 1'b1;
      beat       <= '0;
    end else if (done) begin
      work_valid <= 1'b0;
    end else if (work_valid && out_ready) begin
      beat <= beat + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (work_load) begin
      work <= work_entry;
    end
  end

  // Select the prefix byte, most significant first, or the data byte
  always_comb begin
    out_byte = work.data_byte;
    if (work.prefix) begin
      case (beat)
        3'd0:    out_byte = work.length[31:24];
        3'd1:    out_byte = work.length[23:16];
        3'd2:    out_byte = work.length[15:8];
        3'd3:    out_byte = work.length[7:0];
        default: out_byte = work.data_byte;
      endcase
    end
  end

  assign out_valid       = work_valid;
  assign packet_sequence = work.sequence_num;
  assign fragmented      = work.fragmented;
  assign packet_end      = last && work.packet_end;
  assign run_last        = last;

endmodule

[rtl/packet_fragmenter_with_sequence_unit.sv]
// Top level of the packet fragmenter with sequence numbering
//
// Input channel (in_valid/in_ready) takes one message byte per transaction with
// the total message length and a first-byte flag. Output channel
// (out_valid/out_ready) gives packet payload bytes, each tagged with its packet
// sequence number, a fragmented flag, an end-of-packet mark and run_last on the
// last result of an input byte. A byte passes the input register, then the
// emitter's result register, which shows its first result. Throughput: one byte
// per cycle while out_ready is high; the first byte of a message longer than
// one packet makes five results (four length bytes, then the data) and holds
// the emitter until all are taken. Bytes outside any message are dropped
// without output. The two registers buffer two bytes, so input keeps flowing
// for one byte while the receiver stalls. Reset (rst, synchronous) empties
// both registers, sets the sequence counter to all ones so the first packet
// is zero, and sets the payload length to 508. The user writes the payload
// length register (cfg_wr_en/cfg_wr_data) only while idle; not enforced.
module packet_fragmenter_with_sequence_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic [31:0] message_length,
  input  logic        first_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic [31:0] packet_sequence,
  output logic        fragmented,
  output logic        packet_end,
  output logic        run_last
);
  import fsq_pkg::*;

  in_item_t item;
  work_t    work_entry;
  logic     full;
  logic     pop;
  logic     work_free;
  logic     work_load;

  fsq_input_reg u_in (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .message_length (message_length),
    .first_byte     (first_byte),
    .pop            (pop),
    .full           (full),
    .item           (item)
  );

  fsq_seq_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .full        (full),
    .item        (item),
    .pop         (pop),
    .work_free   (work_free),
    .work_load   (work_load),
    .work_entry  (work_entry)
  );

  fsq_emitter u_emit (
    .clk             (clk),
    .rst             (rst),
    .work_load       (work_load),
    .work_entry      (work_entry),
    .work_free       (work_free),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .packet_sequence (packet_sequence),
    .fragmented      (fragmented),
    .packet_end      (packet_end),
    .run_last        (run_last)
  );

endmodule

[rtl/fsq_checker.sv]
// Port-level checker for the packet fragmenter and its bind
`include "assert_macros.svh"

module fsq_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic [31:0] packet_sequence,
  input logic        fragmented,
  input logic        packet_end,
  input logic        run_last
);

  // Output empty right after reset
  `ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid, "output valid after reset")

  // Stalled output holds its transaction
  `ASSERT_RST(a_out_hold, clk, rst,
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_last),
    "stalled output changed")

  // Prefix bytes never close a packet
  `ASSERT_RST(a_prefix_no_end, clk, rst, out_valid && !run_last |-> !packet_end,
    "packet end on prefix byte")

  // A run keeps one sequence number and flag, with its next beat ready at once
  `ASSERT_RST(a_run_same_seq, clk, rst,
    out_valid && out_ready && !run_last |=>
      out_valid && packet_sequence == $past(packet_sequence) && fragmented,
    "run split or renumbered")

endmodule

bind packet_fragmenter_with_sequence_unit fsq_checker u_fsq_checker (.*);
